FILE: rtl/core/ttce_pkg.sv
// shared constants and helpers for the tensor-train chebyshev evaluator
`timescale 1ns / 1ps
package ttce_pkg;

    // default sizes
    localparam int unsigned DEF_MAX_DIM   = 8;
    localparam int unsigned DEF_RANK_CAP  = 8;
    localparam int unsigned DEF_MAX_TERMS = 8;

    // fixed field widths
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned ADDR_W  = 12;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned VEC_W   = 48;
    localparam int unsigned CFG_W   = 4;
    localparam int unsigned CFG_IDX_W = 1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WEIGHT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RANK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIMS_USED   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLY_DEGREE = 1'd1;

    // register reset values
    localparam logic [3:0] DIMS_USED_RST   = 4'd1;
    localparam logic [2:0] POLY_DEGREE_RST = 3'd3;

    // 1.0 in Q1.30 and in Q23.24
    localparam logic signed [DATA_W-1:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic signed [VEC_W-1:0]  ONE_Q24 = 48'sh0000_0100_0000;

    // magnitude of a signed 32-bit value
    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        abs32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    // saturate to 48 bits signed
    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        if (v > 50'sh0_7FFF_FFFF_FFFF)
            sat48 = 48'sh7FFF_FFFF_FFFF;
        else if (v < -50'sh0_8000_0000_0000)
            sat48 = -48'sh8000_0000_0000;
        else
            sat48 = v[47:0];
    endfunction

    // saturate 48 bits signed to 32 bits signed
    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if (v > 48'sh0000_7FFF_FFFF)
            sat32 = 32'sh7FFF_FFFF;
        else if (v < -48'sh0000_8000_0000)
            sat32 = -32'sh8000_0000;
        else
            sat32 = v[31:0];
    endfunction

endpackage

FILE: rtl/core/ttce_ram.sv
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
module ttce_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

FILE: rtl/core/tensor_train_chebyshev_eval_unit.sv
// top level of the tensor-train chebyshev evaluator
`timescale 1ns / 1ps
// Evaluates a tensor-train model over a Chebyshev basis. Weight (cmd 0) and
// rank (cmd 1) loads, and ignored cmd 3 items, are taken in the idle state
// and do not start the sequencer. A coordinate (cmd 2) reads the ranks rp,
// rn on either side of the current dimension and runs the recurrence up to
// the used degree deg; then each rank pair streams deg+1 weight reads from
// the weight ram through the one shared 32x32 multiplier and forms the
// vector product, which reuses that multiplier for four partial products.
// A coordinate that ends a sample also passes through the emit state.
// One item is worked on at a time; a finished result waits in the output
// register and the next item is taken as soon as it is delivered or parked.
module tensor_train_chebyshev_eval_unit #(
    parameter int unsigned MAX_DIM   = ttce_pkg::DEF_MAX_DIM,
    parameter int unsigned RANK_CAP  = ttce_pkg::DEF_RANK_CAP,
    parameter int unsigned MAX_TERMS = ttce_pkg::DEF_MAX_TERMS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [ttce_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [ttce_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [ttce_pkg::CMD_W-1:0]           s_cmd,
    input  logic [ttce_pkg::ADDR_W-1:0]          s_addr,
    input  logic signed [ttce_pkg::DATA_W-1:0]   s_load_value,
    input  logic signed [ttce_pkg::DATA_W-1:0]   s_coordinate,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ttce_pkg::DATA_W-1:0]   m_model_value
);
    import ttce_pkg::*;

    localparam int unsigned W_COUNT = MAX_DIM * RANK_CAP * MAX_TERMS * RANK_CAP;
    localparam int unsigned WA  = $clog2(W_COUNT > 1 ? W_COUNT : 2);
    localparam int unsigned DCW = $clog2(MAX_DIM + 1);
    localparam int unsigned RW  = $clog2(RANK_CAP + 1);
    localparam int unsigned RIW = RANK_CAP > 1 ? $clog2(RANK_CAP) : 1;
    localparam int unsigned KW  = MAX_TERMS > 1 ? $clog2(MAX_TERMS) : 1;
    localparam int unsigned MW  = 35 + KW;
    localparam int unsigned AW  = 51;
    localparam int unsigned CK_START = 2 % (MAX_TERMS > 2 ? MAX_TERMS : 1 << KW);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_RANK     = 8'b0000_0010,
        S_CHEB_MUL = 8'b0000_0100,
        S_CHEB_ADD = 8'b0000_1000,
        S_MAC      = 8'b0001_0000,
        S_VM       = 8'b0010_0000,
        S_COPY     = 8'b0100_0000,
        S_EMIT     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [3:0]                dims_used_reg;
    logic [2:0]                poly_degree_reg;
    logic [RW-1:0]             rank_reg [MAX_DIM+1];
    logic signed [VEC_W-1:0]   running_reg [RANK_CAP];
    logic signed [VEC_W-1:0]   next_vec_reg [RANK_CAP];
    logic signed [DATA_W-1:0]  bv_reg [MAX_TERMS];
    logic [DCW-1:0]            dim_cnt_reg;
    logic [DCW-1:0]            nd_reg;
    logic [KW-1:0]             deg_reg;
    logic [RW-1:0]             rp_reg, rn_reg;
    logic [RIW-1:0]            r_reg, s_reg;
    logic [KW-1:0]             kk_reg, ck_reg;
    logic                      iss_reg, v1_reg, v2_reg;
    logic                      last1_reg, last2_reg, sgn2_reg;
    logic signed [DATA_W-1:0]  t1_reg;
    logic [63:0]               mul_p_reg;
    logic signed [MW-1:0]      m_acc_reg;
    logic signed [DATA_W-1:0]  x_reg, tp1_reg, tp2_reg;
    logic                      chs_reg;
    logic [VEC_W-1:0]          vma_reg, vmb_reg;
    logic                      vneg_reg, vbig_reg;
    logic [AW-1:0]             vacc_reg;
    logic [2:0]                vstep_reg;
    logic                      out_valid_reg;
    logic signed [DATA_W-1:0]  out_data_reg;

    logic                      in_xfer;
    logic [DCW-1:0]            dimc;
    logic [DCW-1:0]            rank_idx;
    logic [RW-1:0]             rank_rd;
    logic [31:0]               mul_a, mul_b;
    logic                      ram_we, ram_re;
    logic [WA-1:0]             ram_waddr, ram_raddr;
    logic [DATA_W-1:0]         ram_rdata;
    logic                      pair_last_s, pair_last_r;
    logic                      sample_done;

    // chebyshev recurrence step
    logic [34:0]               ch_mag;
    logic signed [36:0]        ch_t;
    logic signed [DATA_W-1:0]  ch_sat;

    // vector product finalize
    logic [48:0]               vm_mag;
    logic signed [49:0]        vm_sp;
    logic signed [VEC_W-1:0]   vm_prod;
    logic signed [VEC_W-1:0]   vm_sum;
    logic signed [MW-1:0]      mac_term;
    logic signed [VEC_W-1:0]   m_val;
    logic signed [VEC_W-1:0]   va_sel;

    assign in_xfer = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_model_value = out_data_reg;

    // dimension index and rank lookup, one read mux
    assign dimc     = (dim_cnt_reg >= DCW'(MAX_DIM)) ? DCW'(MAX_DIM - 1) : dim_cnt_reg;
    assign rank_idx = (state_reg == S_RANK) ? dim_cnt_reg + DCW'(1) : dimc;
    assign rank_rd  = rank_reg[rank_idx];

    // weight ram
    assign ram_we    = in_xfer && (s_cmd == CMD_WEIGHT) && (32'(s_addr) < 32'(W_COUNT));
    assign ram_waddr = WA'(s_addr);
    assign ram_re    = (state_reg == S_MAC) && iss_reg;
    assign ram_raddr = WA'(((int'(dim_cnt_reg) * RANK_CAP + int'(r_reg)) * MAX_TERMS
                           + int'(kk_reg)) * RANK_CAP + int'(s_reg));

    ttce_ram #(
        .WIDTH (DATA_W),
        .DEPTH (W_COUNT)
    ) u_weight_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (s_load_value),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_CHEB_MUL: begin
                mul_a = abs32(x_reg);
                mul_b = abs32(tp1_reg);
            end
            S_MAC: begin
                mul_a = abs32(ram_rdata);
                mul_b = abs32(t1_reg);
            end
            S_VM: begin
                case (vstep_reg)
                    3'd1: begin
                        mul_a = {8'd0, vma_reg[23:0]};
                        mul_b = {8'd0, vmb_reg[23:0]};
                    end
                    3'd2: begin
                        mul_a = {8'd0, vma_reg[47:24]};
                        mul_b = {8'd0, vmb_reg[23:0]};
                    end
                    3'd3: begin
                        mul_a = {8'd0, vma_reg[23:0]};
                        mul_b = {8'd0, vmb_reg[47:24]};
                    end
                    3'd4: begin
                        mul_a = {8'd0, vma_reg[47:24]};
                        mul_b = {8'd0, vmb_reg[47:24]};
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // datapath helpers
    always_comb begin
        ch_mag   = mul_p_reg[63:29];
        ch_t     = (chs_reg ? -$signed({2'b00, ch_mag}) : $signed({2'b00, ch_mag}))
                   - 37'(tp2_reg);
        if (ch_t > 37'sh0_7FFF_FFFF)
            ch_sat = 32'sh7FFF_FFFF;
        else if (ch_t < -37'sh0_8000_0000)
            ch_sat = -32'sh8000_0000;
        else
            ch_sat = ch_t[31:0];

        mac_term = sgn2_reg ? -$signed(MW'({1'b0, mul_p_reg[63:30]}))
                            : $signed(MW'({1'b0, mul_p_reg[63:30]}));
        m_val    = VEC_W'(m_acc_reg);
        va_sel   = running_reg[r_reg];

        vm_mag   = (vbig_reg || (vacc_reg > AW'(49'h1_0000_0000_0000)))
                   ? 49'h1_0000_0000_0000 : vacc_reg[48:0];
        vm_sp    = vneg_reg ? -$signed({1'b0, vm_mag}) : $signed({1'b0, vm_mag});
        vm_prod  = sat48(vm_sp);
        vm_sum   = sat48(50'(next_vec_reg[s_reg]) + 50'(vm_prod));
    end

    assign pair_last_s = !(int'(s_reg) + 1 < int'(rn_reg));
    assign pair_last_r = !(int'(r_reg) + 1 < int'(rp_reg));
    assign sample_done = (int'(dim_cnt_reg) + 1 >= int'(nd_reg));

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_xfer && (s_cmd == CMD_SAMPLE)) begin
                    state_next = S_RANK;
                end
            end
            S_RANK: begin
                state_next = (deg_reg >= KW'(2)) ? S_CHEB_MUL : S_MAC;
            end
            S_CHEB_MUL: begin
                state_next = S_CHEB_ADD;
            end
            S_CHEB_ADD: begin
                state_next = (ck_reg == deg_reg) ? S_MAC : S_CHEB_MUL;
            end
            S_MAC: begin
                if (v2_reg && last2_reg) begin
                    state_next = S_VM;
                end
            end
            S_VM: begin
                if (vstep_reg == 3'd6) begin
                    state_next = (pair_last_s && pair_last_r) ? S_COPY : S_MAC;
                end
            end
            S_COPY: begin
                state_next = sample_done ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state, configuration, ranks and rank vectors
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            dims_used_reg   <= DIMS_USED_RST;
            poly_degree_reg <= POLY_DEGREE_RST;
            dim_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            iss_reg         <= 1'b0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            for (int i = 0; i <= MAX_DIM; i++) begin
                rank_reg[i] <= RW'(1);
            end
            for (int i = 0; i < RANK_CAP; i++) begin
                running_reg[i]  <= (i == 0) ? ONE_Q24 : '0;
                next_vec_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_we) begin
                if (cfg_addr == REG_DIMS_USED) begin
                    dims_used_reg <= cfg_wdata[3:0];
                end else begin
                    poly_degree_reg <= cfg_wdata[2:0];
                end
            end

            // output register
            if (state_reg == S_EMIT && (!out_valid_reg || m_ready)) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end

            // rank loads
            if (in_xfer && s_cmd == CMD_RANK && 32'(s_addr) <= 32'(MAX_DIM)) begin
                if (s_load_value < 32'sd1)
                    rank_reg[DCW'(s_addr)] <= RW'(1);
                else if (s_load_value > 32'(RANK_CAP))
                    rank_reg[DCW'(s_addr)] <= RW'(RANK_CAP);
                else
                    rank_reg[DCW'(s_addr)] <= s_load_value[RW-1:0];
            end

            // sample start: clear the next vector, restart at e0 on dimension zero
            if (in_xfer && s_cmd == CMD_SAMPLE) begin
                dim_cnt_reg <= dimc;
                for (int i = 0; i < RANK_CAP; i++) begin
                    next_vec_reg[i] <= '0;
                    if (dimc == '0) begin
                        running_reg[i] <= (i == 0) ? ONE_Q24 : '0;
                    end
                end
            end

            // weight stream issue and pipeline valids
            if (state_reg == S_MAC) begin
                if (iss_reg) begin
                    v1_reg <= 1'b1;
                    if (kk_reg == deg_reg) begin
                        iss_reg <= 1'b0;
                    end
                end else begin
                    v1_reg <= 1'b0;
                end
                v2_reg <= v1_reg;
            end else begin
                v1_reg <= 1'b0;
                v2_reg <= 1'b0;
                iss_reg <= (state_next == S_MAC);
            end

            // accumulate one product into the next vector
            if (state_reg == S_VM && vstep_reg == 3'd6) begin
                next_vec_reg[s_reg] <= vm_sum;
            end

            // hand the next vector over and step the dimension
            if (state_reg == S_COPY) begin
                for (int i = 0; i < RANK_CAP; i++) begin
                    running_reg[i] <= next_vec_reg[i];
                end
                dim_cnt_reg <= sample_done ? '0 : dim_cnt_reg + DCW'(1);
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        mul_p_reg <= 64'(mul_a) * 64'(mul_b);

        // output payload
        if (state_reg == S_EMIT && (!out_valid_reg || m_ready)) begin
            out_data_reg <= sat32(running_reg[0]);
        end

        // sample start: latch limits, seed the recurrence
        if (in_xfer && s_cmd == CMD_SAMPLE) begin
            nd_reg   <= (dims_used_reg == 4'd0) ? DCW'(1)
                      : (32'(dims_used_reg) > 32'(MAX_DIM)) ? DCW'(MAX_DIM)
                      : DCW'(dims_used_reg);
            deg_reg  <= (32'(poly_degree_reg) > 32'(MAX_TERMS - 1)) ? KW'(MAX_TERMS - 1)
                      : KW'(poly_degree_reg);
            rp_reg   <= rank_rd;
            x_reg    <= s_coordinate;
            tp2_reg  <= ONE_Q30;
            tp1_reg  <= s_coordinate;
            ck_reg   <= KW'(CK_START);
            for (int i = 0; i < MAX_TERMS; i++) begin
                if (i == 0)
                    bv_reg[i] <= ONE_Q30;
                else if (i == 1)
                    bv_reg[i] <= s_coordinate;
            end
        end

        // second rank, reset the rank-pair walk
        if (state_reg == S_RANK) begin
            rn_reg <= rank_rd;
            r_reg  <= '0;
            s_reg  <= '0;
        end

        // chebyshev recurrence
        if (state_reg == S_CHEB_MUL) begin
            chs_reg <= x_reg[31] ^ tp1_reg[31];
        end
        if (state_reg == S_CHEB_ADD) begin
            bv_reg[ck_reg] <= ch_sat;
            tp2_reg        <= tp1_reg;
            tp1_reg        <= ch_sat;
            ck_reg         <= ck_reg + KW'(1);
        end

        // entry to a rank pair
        if (state_reg != S_MAC && state_next == S_MAC) begin
            kk_reg    <= '0;
            m_acc_reg <= '0;
        end

        // weight stream: issue, multiply, accumulate
        if (state_reg == S_MAC) begin
            if (iss_reg) begin
                t1_reg    <= bv_reg[kk_reg];
                last1_reg <= (kk_reg == deg_reg);
                if (kk_reg != deg_reg) begin
                    kk_reg <= kk_reg + KW'(1);
                end
            end
            sgn2_reg  <= ram_rdata[31] ^ t1_reg[31];
            last2_reg <= last1_reg;
            if (v2_reg) begin
                m_acc_reg <= m_acc_reg + mac_term;
            end
        end

        // vector product v[r]*m over four partial products
        if (state_reg == S_MAC && v2_reg && last2_reg) begin
            vstep_reg <= '0;
        end
        if (state_reg == S_VM) begin
            vstep_reg <= vstep_reg + 3'd1;
            case (vstep_reg)
                3'd0: begin
                    vma_reg  <= va_sel[47] ? (~va_sel + 48'd1) : va_sel;
                    vmb_reg  <= m_val[47] ? (~m_val + 48'd1) : m_val;
                    vneg_reg <= va_sel[47] ^ m_val[47];
                    vacc_reg <= '0;
                    vbig_reg <= 1'b0;
                end
                3'd2: begin
                    vacc_reg <= AW'(mul_p_reg[63:24]);
                end
                3'd3, 3'd4: begin
                    vacc_reg <= vacc_reg + AW'(mul_p_reg);
                end
                3'd5: begin
                    if (mul_p_reg[63:24] != '0)
                        vbig_reg <= 1'b1;
                    else
                        vacc_reg <= vacc_reg + AW'({mul_p_reg[23:0], 24'd0});
                end
                3'd6: begin
                    if (pair_last_s) begin
                        s_reg <= '0;
                        r_reg <= r_reg + RIW'(1);
                    end else begin
                        s_reg <= s_reg + RIW'(1);
                    end
                end
                default: begin
                    vacc_reg <= vacc_reg;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // the dimension counter never reaches the dimension limit MAX_DIM
    a_dim_range: assert property (@(posedge aclk) disable iff (!aresetn)
        dim_cnt_reg < DCW'(MAX_DIM))
        else $error("dimension counter out of range");

    // the last weight term of a pair always leads into the vector product
    a_mac_to_vm: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MAC && v2_reg && last2_reg) |=> (state_reg == S_VM))
        else $error("weight stream did not hand over to vector product");

    // a new result is only raised from the emit state
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside emit");

    // ranks in use stay within bounds while the weight stream runs
    a_rank_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MAC) |-> (rp_reg >= RW'(1) && rp_reg <= RW'(RANK_CAP)
                                  && rn_reg >= RW'(1) && rn_reg <= RW'(RANK_CAP)))
        else $error("rank out of range during contraction");
`endif
endmodule

FILE: dv/testbench.sv
// self-checking testbench for the tensor-train chebyshev evaluator
`timescale 1ns / 1ps
module testbench;
    import ttce_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int NUM_DIM    = 8;
    localparam int NUM_RANK   = 8;
    localparam int NUM_TERMS  = 8;
    localparam int NUM_WEIGHT = NUM_DIM * NUM_RANK * NUM_TERMS * NUM_RANK;
    localparam int DRAIN_CYC  = 1200;
    localparam int HOLD_CYC   = 3000;
    localparam int STALL_LIMIT = 20000;
    localparam longint V_HI = (64'sd1 <<< 47) - 1;
    localparam longint V_LO = -(64'sd1 <<< 47);

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_addr;
    logic [CFG_W-1:0]          cfg_wdata;
    logic                      s_valid;
    logic                      s_ready;
    logic [CMD_W-1:0]          s_cmd;
    logic [ADDR_W-1:0]         s_addr;
    logic signed [DATA_W-1:0]  s_load_value;
    logic signed [DATA_W-1:0]  s_coordinate;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [DATA_W-1:0]  m_model_value;

    tensor_train_chebyshev_eval_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_addr        (s_addr),
        .s_load_value  (s_load_value),
        .s_coordinate  (s_coordinate),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_model_value (m_model_value)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic signed [31:0] core_w [NUM_WEIGHT];
    int                 rank_tab [NUM_DIM+1];
    longint             vec_acc [NUM_RANK];
    longint             basis_t [NUM_TERMS];
    int                 dim_pos;
    logic [3:0]         cur_dims;
    logic [2:0]         cur_deg;

    logic signed [31:0] model_q [$];
    int                 err_count = 0;
    bit                 calm = 1'b0;
    bit                 tx_idle_en = 1'b0;
    bit                 rx_idle_en = 1'b0;
    bit                 hold_req = 1'b0;
    int                 idle_cyc = 0;

    // directed stimulus table
    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [ADDR_W-1:0]  addr;
        logic signed [31:0] lv;
        logic signed [31:0] coord;
        bit                 typed;
        logic signed [31:0] want;
    } stim_t;

    localparam int DIR_N = 22;
    stim_t dir_tab [DIR_N] = '{
        // single weight of 1.0 on T_0 gives exactly 1.0
        '{CMD_WEIGHT, 12'd0,  32'sh0100_0000, 32'sh0, 1'b0, 32'sh0},
        '{CMD_WEIGHT, 12'd8,  32'sh0,         32'sh0, 1'b0, 32'sh0},
        '{CMD_WEIGHT, 12'd16, 32'sh0,         32'sh0, 1'b0, 32'sh0},
        '{CMD_WEIGHT, 12'd24, 32'sh0,         32'sh0, 1'b0, 32'sh0},
        '{CMD_SAMPLE, 12'd0,  32'sh0, 32'sh1234_5678, 1'b1, 32'sh0100_0000},
        // positive and negative saturation of the output
        '{CMD_WEIGHT, 12'd0,  32'sh7FFF_FFFF, 32'sh0, 1'b0, 32'sh0},
        '{CMD_WEIGHT, 12'd8,  32'sh7FFF_FFFF, 32'sh0, 1'b0, 32'sh0},
        '{CMD_SAMPLE, 12'd0,  32'sh0, 32'sh4000_0000, 1'b1, 32'sh7FFF_FFFF},
        '{CMD_WEIGHT, 12'd0,  32'sh8000_0000, 32'sh0, 1'b0, 32'sh0},
        '{CMD_WEIGHT, 12'd8,  32'sh8000_0000, 32'sh0, 1'b0, 32'sh0},
        '{CMD_SAMPLE, 12'd0,  32'sh0, 32'sh4000_0000, 1'b1, 32'sh8000_0000},
        // rank clamping, ignored rank index, leading rank above one
        '{CMD_RANK,   12'd1,  32'sh0,         32'sh0, 1'b0, 32'sh0},
        '{CMD_RANK,   12'd1,  32'sd100,       32'sh0, 1'b0, 32'sh0},
        '{CMD_RANK,   12'd9,  32'sd5,         32'sh0, 1'b0, 32'sh0},
        '{CMD_RANK,   12'hFFF, 32'sd3,        32'sh0, 1'b0, 32'sh0},
        '{CMD_RANK,   12'd0,  32'sd8,         32'sh0, 1'b0, 32'sh0},
        '{CMD_WEIGHT, 12'hFFF, 32'sh0080_0000, 32'sh0, 1'b0, 32'sh0},
        '{CMD_UNUSED, 12'hFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 32'sh0},
        // coordinate extremes
        '{CMD_SAMPLE, 12'hFFF, 32'shFFFF_FFFF, 32'sh8000_0000, 1'b0, 32'sh0},
        '{CMD_SAMPLE, 12'd0,  32'sh0, 32'sh7FFF_FFFF, 1'b0, 32'sh0},
        '{CMD_SAMPLE, 12'd0,  32'sh0, 32'sh0,         1'b0, 32'sh0},
        '{CMD_SAMPLE, 12'd0,  32'sh0, 32'shC000_0000, 1'b0, 32'sh0}
    };

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // arithmetic shift that truncates toward zero
    function automatic longint shift_tz(longint v, int n);
        if (v < 0)
            return -((-v) >>> n);
        return v >>> n;
    endfunction

    // q23.24 product, truncated, saturated to 48 bits
    function automatic longint mul_q24(longint a, longint b);
        bit                neg;
        longint unsigned   ua, ub, ah, al, bh, bl, hh, mag;
        longint            sv;
        neg = (a < 0) != (b < 0);
        ua = a < 0 ? longint'(-a) : a;
        ub = b < 0 ? longint'(-b) : b;
        ah = ua >> 24;
        al = ua & 64'hFF_FFFF;
        bh = ub >> 24;
        bl = ub & 64'hFF_FFFF;
        hh = ah * bh;
        if (hh >= (64'd1 << 24))
            mag = 64'd1 << 48;
        else
            mag = (hh << 24) + ah * bl + al * bh + ((al * bl) >> 24);
        if (mag > (64'd1 << 48))
            mag = 64'd1 << 48;
        sv = neg ? -longint'(mag) : longint'(mag);
        return clip(sv, V_LO, V_HI);
    endfunction

    // one coordinate through the model; returns 1 when a sample completes
    function automatic bit eval_coordinate(input logic signed [31:0] x,
                                           output logic signed [31:0] y);
        int     nd, deg, rp, rn, idx;
        longint xv, t, m;
        longint nxt [NUM_RANK];
        nd  = cur_dims < 1 ? 1 : (cur_dims > NUM_DIM ? NUM_DIM : int'(cur_dims));
        deg = int'(cur_deg);
        y = '0;
        if (dim_pos >= NUM_DIM)
            dim_pos = NUM_DIM - 1;
        if (dim_pos == 0) begin
            foreach (vec_acc[i]) vec_acc[i] = 0;
            vec_acc[0] = 64'sd1 <<< 24;
        end
        // chebyshev basis
        xv = longint'(x);
        basis_t[0] = 64'sd1 <<< 30;
        if (deg >= 1)
            basis_t[1] = xv;
        for (int k = 2; k <= deg; k++) begin
            t = shift_tz(xv * basis_t[k-1], 29) - basis_t[k-2];
            basis_t[k] = clip(t, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
        end
        // contraction with the current core
        rp = rank_tab[dim_pos];
        rn = rank_tab[dim_pos+1];
        foreach (nxt[i]) nxt[i] = 0;
        for (int r = 0; r < rp; r++) begin
            for (int s = 0; s < rn; s++) begin
                m = 0;
                for (int k = 0; k <= deg; k++) begin
                    idx = ((dim_pos * NUM_RANK + r) * NUM_TERMS + k) * NUM_RANK + s;
                    m += shift_tz(basis_t[k] * longint'(core_w[idx]), 30);
                end
                m = clip(m, V_LO, V_HI);
                nxt[s] = clip(nxt[s] + mul_q24(vec_acc[r], m), V_LO, V_HI);
            end
        end
        foreach (vec_acc[i]) vec_acc[i] = nxt[i];
        dim_pos++;
        if (dim_pos >= nd) begin
            y = 32'(clip(vec_acc[0], -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1));
            dim_pos = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // update the predictor for an accepted transfer
    task automatic apply_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                              input logic signed [31:0] lv, input logic signed [31:0] coord,
                              input bit typed, input logic signed [31:0] want);
        logic signed [31:0] y;
        case (cmd)
            CMD_WEIGHT: begin
                core_w[addr] = lv;
            end
            CMD_RANK: begin
                if (addr <= NUM_DIM)
                    rank_tab[addr] = int'(clip(longint'(lv), 1, NUM_RANK));
            end
            CMD_SAMPLE: begin
                if (eval_coordinate(coord, y))
                    model_q.push_back(typed ? want : y);
            end
            default: ;
        endcase
    endtask

    // offer one input transfer and wait for acceptance
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                             input logic signed [31:0] lv, input logic signed [31:0] coord,
                             input bit typed, input logic signed [31:0] want);
        int gap;
        gap = (tx_idle_en && !calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_addr       <= addr;
        s_load_value <= lv;
        s_coordinate <= coord;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_item(cmd, addr, lv, coord, typed, want);
    endtask

    // let the block drain before touching a register
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (model_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    // one register write; the caller drops the write enable afterwards
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx == REG_DIMS_USED)
            cur_dims = val[3:0];
        else
            cur_deg = val[2:0];
        @(posedge aclk);
    endtask

    function automatic logic signed [31:0] rand_weight();
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return 32'(longint'($urandom_range(0, 32'h0200_0000)) - 64'sd16777216);
    endfunction

    function automatic logic signed [31:0] rand_coord();
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return 32'(longint'($urandom_range(0, 32'h8000_0000)) - 64'sd1073741824);
    endfunction

    // one random transfer, mostly coordinates
    task automatic send_random();
        int                 pick;
        logic [ADDR_W-1:0]  addr;
        logic signed [31:0] val;
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
            send_item(CMD_SAMPLE, ADDR_W'($urandom), 32'($urandom), rand_coord(), 1'b0, '0);
        end else if (pick < 80) begin
            send_item(CMD_WEIGHT, ADDR_W'($urandom), rand_weight(), 32'($urandom), 1'b0, '0);
        end else if (pick < 94) begin
            addr = ($urandom_range(0, 6) == 0) ? ADDR_W'($urandom) : ADDR_W'($urandom_range(0, 8));
            val  = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(1, 8));
            send_item(CMD_RANK, addr, val, 32'($urandom), 1'b0, '0);
        end else begin
            send_item(CMD_UNUSED, ADDR_W'($urandom), 32'($urandom), 32'($urandom), 1'b0, '0);
        end
    endtask

    task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                   input logic signed [31:0] want);
        $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (model_q.size() == 0)
                report_mismatch("result with nothing pending", m_model_value, '0);
            else if (m_model_value !== model_q[0])
                report_mismatch("model_value", m_model_value, model_q.pop_front());
            else
                void'(model_q.pop_front());
        end
    end

    // receiver side: random stalls plus one long hold-off
    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYC) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (rx_idle_en && !calm && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on transfer progress
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // main sequence
    initial begin
        logic [3:0] ph_dims [7];
        logic [2:0] ph_deg  [7];
        ph_dims      = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5, 4'd2};
        ph_deg       = '{3'd0, 3'd7, 3'd7, 3'd1, 3'd5, 3'd4, 3'd2};
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_cmd        = '0;
        s_addr       = '0;
        s_load_value = '0;
        s_coordinate = '0;
        foreach (rank_tab[i]) rank_tab[i] = 1;
        foreach (vec_acc[i]) vec_acc[i] = 0;
        vec_acc[0] = 64'sd1 <<< 24;
        dim_pos  = 0;
        cur_dims = DIMS_USED_RST;
        cur_deg  = POLY_DEGREE_RST;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill the whole weight store so no read ever hits an unwritten entry
        for (int a = 0; a < NUM_WEIGHT; a++)
            send_item(CMD_WEIGHT, ADDR_W'(a), rand_weight(), '0, 1'b0, '0);

        // directed table
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        foreach (dir_tab[i])
            send_item(dir_tab[i].cmd, dir_tab[i].addr, dir_tab[i].lv, dir_tab[i].coord,
                      dir_tab[i].typed, dir_tab[i].want);

        // random phases under several register settings
        for (int ph = 0; ph < 7; ph++) begin
            wait_drained();
            write_reg(REG_DIMS_USED, ph == 5 ? CFG_W'($urandom_range(0, 15)) : ph_dims[ph]);
            write_reg(REG_POLY_DEGREE, ph == 5 ? CFG_W'($urandom_range(0, 7)) : CFG_W'(ph_deg[ph]));
            cfg_we <= 1'b0;
            tx_idle_en = (ph % 2) == 0;
            rx_idle_en = (ph % 3) != 1;
            calm = (ph == 6);
            if (ph == 2) begin
                tx_idle_en = 1'b0;
                hold_req = 1'b1;
            end
            for (int n = 0; n < 57; n++)
                send_random();
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (model_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (err_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

FILE: tensor_train_chebyshev_eval_unit.f
rtl/core/ttce_pkg.sv
rtl/core/ttce_ram.sv
rtl/core/tensor_train_chebyshev_eval_unit.sv
dv/testbench.sv
